FILE: hdl/efpr_pkg.sv
// Shared types and constants of the framed ping-pong receiver.
package efpr_pkg;

  localparam int unsigned LenW = 6;

  localparam logic [7:0] ByteNul = 8'd0;
  localparam logic [7:0] ByteCr  = 8'd13;
  localparam logic [7:0] ByteLf  = 8'd10;

  localparam logic [LenW-1:0] MaxResults = 6'd63;

  localparam logic CmdRx  = 1'b0;
  localparam logic CmdPop = 1'b1;

  localparam logic CfgStart = 1'b0;
  localparam logic CfgEnd   = 1'b1;

  localparam logic [7:0] StartReset = 8'd2;
  localparam logic [7:0] EndReset   = 8'd3;

  // What a pop has to deliver, as seen when the pop is taken.
  typedef struct packed {
    logic            avail;
    logic [LenW-1:0] len;
    logic [LenW-1:0] count;
  } pop_cmd_t;

  typedef enum logic [1:0] {
    StIdle   = 2'b01,
    StStream = 2'b10
  } pop_state_e;

endpackage

FILE: hdl/efpr_store.sv
// Two-half message memory with one write port and one registered read port.
module efpr_store #(
  parameter int unsigned AddrW = 7
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem_q [2**AddrW];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data holds until the next read, so a stalled result keeps its byte.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/efpr_rx.sv
// Receive path: byte filtering, fill index, half swap and message bookkeeping.
module efpr_rx #(
  parameter int unsigned HALF_BYTES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                byte_go_i,
  input  logic [7:0]                          byte_i,
  input  logic                                pop_go_i,
  input  logic [7:0]                          start_char_i,
  input  logic [7:0]                          end_char_i,
  output logic                                wr_en_o,
  output logic [$clog2(HALF_BYTES):0]         wr_addr_o,
  output efpr_pkg::pop_cmd_t                  pop_cmd_o,
  output logic                                rd_half_o,
  output logic                                pending_o
);

  import efpr_pkg::*;

  localparam int unsigned IdxW = $clog2(HALF_BYTES);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(HALF_BYTES - 1);

  logic            half_q, half_d;
  logic [IdxW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] done_q, done_d;
  logic            pending_q, pending_d;
  logic            drop, is_end;
  logic [LenW-1:0] len6;

  assign drop = (byte_i == ByteNul) || (byte_i == ByteCr) || (byte_i == ByteLf) ||
                (byte_i == start_char_i);
  assign is_end = !drop && (byte_i == end_char_i);

  always_comb begin
    half_d    = half_q;
    fill_d    = fill_q;
    done_d    = done_q;
    pending_d = pending_q;
    if (pop_go_i) begin
      pending_d = 1'b0;
    end
    if (byte_go_i && is_end) begin
      done_d    = fill_q;
      fill_d    = '0;
      half_d    = ~half_q;
      pending_d = 1'b1;
    end else if (byte_go_i && !drop) begin
      fill_d = (fill_q == IdxLast) ? '0 : fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q    <= 1'b1;
      fill_q    <= '0;
      done_q    <= '0;
      pending_q <= 1'b0;
    end else begin
      half_q    <= half_d;
      fill_q    <= fill_d;
      done_q    <= done_d;
      pending_q <= pending_d;
    end
  end

  assign wr_en_o   = byte_go_i && !drop && !is_end;
  assign wr_addr_o = {half_q, fill_q};

  assign len6 = LenW'(done_q);

  always_comb begin
    pop_cmd_o.avail = pending_q;
    pop_cmd_o.len   = pending_q ? len6 : '0;
    if (!pending_q) begin
      pop_cmd_o.count = '0;
    end else if (32'(done_q) > 32'(MaxResults)) begin
      pop_cmd_o.count = MaxResults;
    end else begin
      pop_cmd_o.count = len6;
    end
  end

  assign rd_half_o = ~half_q;
  assign pending_o = pending_q;

endmodule

FILE: hdl/efpr_pop.sv
// Pop sequencer: issues memory reads and fills the output register.
module efpr_pop #(
  parameter int unsigned IdxW = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_go_i,
  input  efpr_pkg::pop_cmd_t pop_cmd_i,
  input  logic               rd_half_i,
  input  logic               out_ready_i,
  output logic               busy_o,
  output logic               rd_en_o,
  output logic [IdxW:0]      rd_addr_o,
  output logic               out_valid_o,
  output logic               out_avail_o,
  output logic [efpr_pkg::LenW-1:0] out_len_o,
  output logic               out_has_o,
  output logic               out_last_o
);

  import efpr_pkg::*;

  pop_state_e      state_q, state_d;
  pop_cmd_t        cmd_q;
  logic            half_q;
  logic [LenW-1:0] cnt_q;
  logic            valid_q, valid_d;
  logic            avail_q, has_q, last_q;
  logic [LenW-1:0] len_q;
  logic            single, slot_free, load, is_last;

  assign single    = !cmd_q.avail || (cmd_q.count == '0);
  assign slot_free = !valid_q || out_ready_i;
  assign load      = (state_q == StStream) && slot_free;
  assign is_last   = single || ((cnt_q + 6'd1) == cmd_q.count);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (pop_go_i) begin
          state_d = StStream;
        end
      end
      StStream: begin
        if (load && is_last) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_go_i) begin
      cmd_q  <= pop_cmd_i;
      half_q <= rd_half_i;
      cnt_q  <= '0;
    end else if (load) begin
      cnt_q <= cnt_q + 1'b1;
    end
    if (load) begin
      avail_q <= cmd_q.avail;
      len_q   <= cmd_q.len;
      has_q   <= !single;
      last_q  <= is_last;
    end
  end

  assign busy_o      = (state_q == StStream);
  assign rd_en_o     = load && !single;
  assign rd_addr_o   = {half_q, IdxW'(cnt_q)};
  assign out_valid_o = valid_q;
  assign out_avail_o = avail_q;
  assign out_len_o   = len_q;
  assign out_has_o   = has_q;
  assign out_last_o  = last_q;

endmodule

FILE: hdl/etx_framed_pingpong_receiver.sv
// Top level of the framed ping-pong receiver with its stream and register ports.
// Flow: a received byte is stored at the edge of its transfer; a pop first enters
//   the streaming state, then loads one result per cycle while the output is ready.
// Throughput: one received byte per cycle while no pop streams; a pop holds the input
//   off until its last result is loaded, as the memory has a single read port.
// Reset: asynchronous, active low; state and character registers clear at once.
//   Data registers and the message memory do not; memory holds junk until written.
module etx_framed_pingpong_receiver #(
  parameter int unsigned HALF_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] cmd
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [5:0] msg_len, [13:6] data_byte, [15:14] zero
  output logic [1:0]  m_axis_tuser_o,   // [0] available, [1] has_byte
  output logic        m_axis_tlast_o,
  // Register write port.
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);

  import efpr_pkg::*;

  localparam int unsigned IdxW = $clog2(HALF_BYTES);

  logic [7:0]      start_char_q, end_char_q;
  logic            in_xfer, byte_go, pop_go;
  logic            wr_en, rd_en, rd_half, pending, busy;
  logic [IdxW:0]   wr_addr, rd_addr;
  logic [7:0]      rd_data;
  pop_cmd_t        pop_cmd;
  logic            out_avail, out_has, out_last;
  logic [LenW-1:0] out_len;

  // Config registers; the user sends writes only while the block is quiet; not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_char_q <= StartReset;
      end_char_q   <= EndReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStart: start_char_q <= cfg_wdata_i;
        CfgEnd:   end_char_q   <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  // While a pop streams, the input is held off. That keeps memory writes away from
  // the reads of the pop and fixes the order of results.
  assign s_axis_tready_o = !busy;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign byte_go = in_xfer && (s_axis_tuser_i == CmdRx);
  assign pop_go  = in_xfer && (s_axis_tuser_i == CmdPop);

  efpr_rx #(
    .HALF_BYTES (HALF_BYTES)
  ) u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_go_i    (byte_go),
    .byte_i       (s_axis_tdata_i),
    .pop_go_i     (pop_go),
    .start_char_i (start_char_q),
    .end_char_i   (end_char_q),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .pop_cmd_o    (pop_cmd),
    .rd_half_o    (rd_half),
    .pending_o    (pending)
  );

  // The memory is addressed as {half, index}, so each half spans a power of two.
  efpr_store #(
    .AddrW (IdxW + 1)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  efpr_pop #(
    .IdxW (IdxW)
  ) u_pop (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_go_i    (pop_go),
    .pop_cmd_i   (pop_cmd),
    .rd_half_i   (rd_half),
    .out_ready_i (m_axis_tready_i),
    .busy_o      (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .out_valid_o (m_axis_tvalid_o),
    .out_avail_o (out_avail),
    .out_len_o   (out_len),
    .out_has_o   (out_has),
    .out_last_o  (out_last)
  );

  // The memory read register serves as the data half of the output register; it
  // only changes when a new result is loaded, so a stalled transfer stays stable.
  assign m_axis_tdata_o = {2'b00, (out_has ? rd_data : 8'd0), out_len};
  assign m_axis_tuser_o = {out_has, out_avail};
  assign m_axis_tlast_o = out_last;

  // A memory read and a memory write never fall in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_en |-> !wr_en)
    else $error("message memory read and write collide");

  // A result that carries a byte always belongs to an available message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tuser_o[0])
    else $error("byte result without an available message");

  // Taking a pop always consumes the pending message.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_go |=> !pending)
    else $error("message still pending after a pop");

  // A result that is not available carries no length and is marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid_o && !m_axis_tuser_o[0] |-> (m_axis_tdata_o[5:0] == 6'd0) && m_axis_tlast_o)
    else $error("not-available result is malformed");

endmodule

FILE: verif/etx_framed_pingpong_receiver_tb.sv
// Self-checking testbench of the framed ping-pong receiver: directed framing cases, then random traffic.
module etx_framed_pingpong_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efpr_pkg::*;

  // The predictor indexes the store as {half, fill}, so it relies on 64-byte halves.
  localparam int unsigned HalfBytes   = 64;
  localparam int unsigned ResetCycles = 9;
  // Extra settling after the last due result, to cover the pipeline.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned DrainCycles  = 10;
  // Cycles without any transfer or register write before the run is declared hung.
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PhaseItems   = 10;

  // One output transfer as the predictor expects it.
  typedef struct packed {
    logic            avail;
    logic [LenW-1:0] len;
    logic            has;
    logic [7:0]      data;
    logic            last;
  } pop_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;   // [7:0] rx_byte
  logic        s_axis_tuser_i;   // [0] cmd
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // [5:0] msg_len, [13:6] data_byte, [15:14] zero
  logic [1:0]  m_axis_tuser_o;   // [0] available, [1] has_byte
  logic        m_axis_tlast_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_wdata_i;

  etx_framed_pingpong_receiver #(
    .HALF_BYTES(HalfBytes)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Predictor state: a private copy of the block's registers and message memory.
  logic [7:0]      msg_bytes [2*HalfBytes];
  logic            fill_half;
  logic [LenW-1:0] fill_pos;
  logic [LenW-1:0] closed_len;
  logic            msg_waiting;
  logic [7:0]      start_char_q;
  logic [7:0]      end_char_q;

  // Output transfers that are due, oldest first.
  pop_beat_t expected_beats[$];

  // Idling switches for the input side (gaps) and the output side (stalls).
  bit tx_gaps_on;
  bit rx_stalls_on;

  int unsigned errors;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned msgs_popped;
  int unsigned empty_pops;
  int unsigned settings_used;

  // Free-running clock with a 20 ns period.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // The output side is ready most of the time; when stalls are enabled it drops
  // tready with a probability of 15 percent. It changes only at the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready_i = !(rx_stalls_on && ($urandom_range(0, 99) < 15));
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Advances the predictor by one accepted input transfer and queues the
  // output transfers it causes. Received bytes never produce output.
  task automatic predict_transfer(input logic cmd, input logic [7:0] rx);
    pop_beat_t beat;
    int        i;
    if (cmd == CmdRx) begin
      // Filler characters and the start character are dropped before the
      // end character is even looked at, so a clashing end character is lost.
      if (rx == ByteNul || rx == ByteCr || rx == ByteLf || rx == start_char_q) begin
        return;
      end
      if (rx == end_char_q) begin
        closed_len  = fill_pos;
        fill_pos    = '0;
        fill_half   = ~fill_half;
        msg_waiting = 1'b1;
      end else begin
        // The 6-bit position wraps on its own, overwriting an overlong message.
        msg_bytes[{fill_half, fill_pos}] = rx;
        fill_pos = fill_pos + 1'b1;
      end
    end else if (!msg_waiting) begin
      beat = '{avail: 1'b0, len: '0, has: 1'b0, data: 8'h00, last: 1'b1};
      expected_beats.push_back(beat);
      empty_pops++;
    end else begin
      msg_waiting = 1'b0;
      msgs_popped++;
      if (closed_len == 0) begin
        // A message closed with no bytes pops as a single available marker.
        beat = '{avail: 1'b1, len: '0, has: 1'b0, data: 8'h00, last: 1'b1};
        expected_beats.push_back(beat);
      end else begin
        // The completed half is the one not being filled.
        for (i = 0; i < int'(closed_len); i++) begin
          beat.avail = 1'b1;
          beat.len   = closed_len;
          beat.has   = 1'b1;
          beat.data  = msg_bytes[{~fill_half, i[LenW-1:0]}];
          beat.last  = (i == int'(closed_len) - 1);
          expected_beats.push_back(beat);
        end
      end
    end
  endtask

  // Compares every output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    pop_beat_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (expected_beats.size() == 0) begin
        report_mismatch("output transfer with nothing expected", 32'(m_axis_tdata_o), 0);
      end else begin
        want = expected_beats.pop_front();
        if (m_axis_tuser_o[0] !== want.avail)
          report_mismatch("available", 32'(m_axis_tuser_o[0]), 32'(want.avail));
        if (m_axis_tdata_o[5:0] !== want.len)
          report_mismatch("msg_len", 32'(m_axis_tdata_o[5:0]), 32'(want.len));
        if (m_axis_tuser_o[1] !== want.has)
          report_mismatch("has_byte", 32'(m_axis_tuser_o[1]), 32'(want.has));
        if (m_axis_tdata_o[13:6] !== want.data)
          report_mismatch("data_byte", 32'(m_axis_tdata_o[13:6]), 32'(want.data));
        if (m_axis_tlast_o !== want.last)
          report_mismatch("last", 32'(m_axis_tlast_o), 32'(want.last));
        if (m_axis_tdata_o[15:14] !== 2'b00)
          report_mismatch("tdata padding", 32'(m_axis_tdata_o[15:14]), 0);
      end
    end
  end

  // Ends the run if nothing moves on any port for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
          || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no transfer for %0d cycles, %0d results still due",
             StallLimit, expected_beats.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Offers one item at a falling edge, optionally after a random gap, and
  // waits for the transfer. Returns at the next falling edge with tvalid low,
  // so a following call can raise it again in the same step.
  task automatic send_item(input logic cmd, input logic [7:0] rx);
    int unsigned gap;
    if (tx_gaps_on && ($urandom_range(0, 99) < 15)) begin
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = cmd;
    s_axis_tdata_i  = rx;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_transfer(cmd, rx);
    items_sent++;
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  // Holds off the input until every due result has come out, then lets the
  // block finish any work that produces no result.
  task automatic wait_for_results();
    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Register writes happen only while the block is idle.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    wait_for_results();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgStart) begin
      start_char_q = value;
    end else begin
      end_char_q = value;
    end
  endtask

  // Random byte, with the dropped characters favored now and then.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0:       return ByteNul;
      1:       return ByteCr;
      2:       return ByteLf;
      3:       return start_char_q;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Pending-flag handling, dropped characters, field extremes, empty and
  // replaced messages, all under the reset register values.
  task automatic test_framing_basics();
    send_item(CmdPop, 8'h00);          // nothing pending yet
    send_item(CmdRx, ByteNul);
    send_item(CmdRx, ByteCr);
    send_item(CmdRx, ByteLf);
    send_item(CmdRx, StartReset);
    send_item(CmdRx, 8'hFF);
    send_item(CmdRx, 8'h01);
    send_item(CmdRx, 8'h80);
    send_item(CmdRx, 8'h7F);
    send_item(CmdRx, EndReset);
    send_item(CmdPop, 8'hFF);          // four-byte message; rx_byte is ignored
    send_item(CmdRx, EndReset);        // message with no bytes
    send_item(CmdPop, 8'h00);
    // An unpopped message is replaced by the next one.
    send_item(CmdRx, 8'h41);
    send_item(CmdRx, EndReset);
    send_item(CmdRx, 8'h42);
    send_item(CmdRx, 8'h43);
    send_item(CmdRx, EndReset);
    send_item(CmdPop, 8'h00);
  endtask

  // An end character equal to the start character or to CR is dropped and
  // never closes a message.
  task automatic test_register_clash();
    write_reg(CfgStart, 8'h55);
    write_reg(CfgEnd, 8'h55);
    send_item(CmdRx, 8'h78);
    send_item(CmdRx, 8'h55);
    send_item(CmdPop, 8'h00);
    write_reg(CfgEnd, ByteCr);
    send_item(CmdRx, 8'h79);
    send_item(CmdRx, ByteCr);
    send_item(CmdPop, 8'h00);
  endtask

  // Short well-formed frames with random content, mixed with stray bytes and
  // stray pops; one phase instead sends a frame longer than a half, which
  // wraps the fill position and overwrites its oldest bytes.
  task automatic test_random_traffic();
    logic [7:0]  starts [5] = '{8'h00, 8'hFF, 8'h00, StartReset, 8'h00};
    logic [7:0]  ends   [5] = '{8'hFF, 8'h00, 8'h00, EndReset,   8'h00};
    int unsigned phase;
    int unsigned first_item;
    int unsigned frame_len;
    int unsigned roll;
    bit          paused;
    for (phase = 0; phase < 5; phase++) begin
      // Phases two and four use random characters, zero and one the extremes, three the reset values.
      if (phase == 2 || phase == 4) begin
        starts[phase] = 8'($urandom_range(0, 255));
        ends[phase]   = 8'($urandom_range(0, 255));
      end
      write_reg(CfgStart, starts[phase]);
      write_reg(CfgEnd, ends[phase]);
      settings_used++;
      // Phase two runs without any idling on either side.
      tx_gaps_on   = (phase != 2);
      rx_stalls_on = (phase != 2);
      first_item = items_sent;
      paused     = 1'b0;
      if (phase == 3) begin
        // Printable characters are never dropped and never end the frame here.
        repeat (HalfBytes + 6) send_item(CmdRx, 8'($urandom_range(32, 126)));
        send_item(CmdRx, end_char_q);
        send_item(CmdPop, 8'h00);
      end
      while (items_sent - first_item < PhaseItems) begin
        if (!paused && (items_sent - first_item >= PhaseItems / 2)) begin
          // The sender waits for every due result before going on.
          wait_for_results();
          paused = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          frame_len = $urandom_range(0, 10);
          repeat (frame_len) send_item(CmdRx, pick_byte());
          send_item(CmdRx, end_char_q);
          if ($urandom_range(0, 99) < 80) begin
            send_item(CmdPop, 8'($urandom_range(0, 255)));
          end
        end else if (roll < 85) begin
          send_item(CmdRx, pick_byte());
        end else begin
          send_item(CmdPop, 8'($urandom_range(0, 255)));
        end
      end
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tuser_i  = CmdRx;
    m_axis_tready_i = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CfgStart;
    cfg_wdata_i     = 8'h00;
    tx_gaps_on      = 1'b1;
    rx_stalls_on    = 1'b1;
    errors          = 0;
    items_sent      = 0;
    results_seen    = 0;
    msgs_popped     = 0;
    empty_pops      = 0;
    settings_used   = 1;

    // Predictor reset: the store contents stay unused until written.
    foreach (msg_bytes[i]) msg_bytes[i] = 8'h00;
    fill_half    = 1'b1;
    fill_pos     = '0;
    closed_len   = '0;
    msg_waiting  = 1'b0;
    start_char_q = StartReset;
    end_char_q   = EndReset;

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_framing_basics();
    test_register_clash();
    test_random_traffic();

    wait_for_results();
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d input transfers under %0d register settings: %0d messages popped,",
             items_sent, settings_used, msgs_popped);
    $display("  %0d pops with nothing pending, %0d output transfers checked, %0d mismatches.",
             empty_pops, results_seen, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: etx_framed_pingpong_receiver.f
hdl/efpr_pkg.sv
hdl/efpr_store.sv
hdl/efpr_rx.sv
hdl/efpr_pop.sv
hdl/etx_framed_pingpong_receiver.sv
verif/etx_framed_pingpong_receiver_tb.sv
